// ===== rtl/core/rtic_pkg.sv =====
// Shared types, register map and constants of the raster timing and interrupt controller.
`timescale 1ns / 1ps

package rtic_pkg;

	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;

	localparam logic [5:0] ADDR_CR1    = 6'h11;
	localparam logic [5:0] ADDR_RASTER = 6'h12;
	localparam logic [5:0] ADDR_CR2    = 6'h16;
	localparam logic [5:0] ADDR_MEMPTR = 6'h18;
	localparam logic [5:0] ADDR_IRR    = 6'h19;
	localparam logic [5:0] ADDR_IMR    = 6'h1A;
	localparam logic [5:0] ADDR_MM     = 6'h1E;
	localparam logic [5:0] ADDR_MD     = 6'h1F;
	localparam logic [5:0] ADDR_BORDER = 6'h20;
	localparam logic [5:0] ADDR_BG0    = 6'h21;
	localparam logic [5:0] ADDR_UNUSED = 6'h2F;

	localparam logic [7:0] CR1_RST    = 8'h1B;
	localparam logic [7:0] CR2_RST    = 8'hC8;
	localparam logic [7:0] MEMPTR_RST = 8'h14;
	localparam logic [7:0] BORDER_RST = 8'h0E;
	localparam logic [7:0] BG0_RST    = 8'h06;

	localparam logic [7:0] IRR_FORCED   = 8'h70;
	localparam logic [7:0] IMR_FORCED   = 8'hF0;
	localparam logic [7:0] OPEN_BUS     = 8'hFF;
	localparam logic [7:0] IRQ_SRC_MASK = 8'h0F;
	localparam logic [7:0] IRQ_RASTER   = 8'h01;
	localparam logic [7:0] IRQ_ANY      = 8'h80;

	localparam int LINES_PER_FRAME = 312;
	localparam int TEXT_ROWS       = 25;
	localparam int TEXT_COLS       = 40;
	localparam int BAD_LINE_CYCLE  = 12;
	localparam int FETCH_CYCLE     = 14;
	localparam int BA_LAST_CYCLE   = 54;

	localparam logic [8:0] LINE_LAST  = 9'(LINES_PER_FRAME - 1);
	localparam logic [8:0] DISP_FIRST = 9'd48;
	localparam logic [8:0] DISP_LAST  = 9'd247;

	typedef struct packed {
		logic       den;
		logic [2:0] ysc;
		logic [3:0] matrix_base;
	} ctl_t;

	typedef struct packed {
		logic [8:0]  line;
		logic [8:0]  line_next;
		logic        cyc_one;
		logic        wrap;
		logic [5:0]  cycle_next;
		logic        bad_next;
		logic        ba_next;
		logic        frame_end;
		logic        fetch_valid;
		logic [4:0]  fetch_row;
		logic [13:0] fetch_addr;
	} tim_t;

	function automatic logic [7:0] reg_reset_val(input logic [5:0] addr);
		logic [7:0] v;
		case (addr)
			ADDR_CR2:    v = CR2_RST;
			ADDR_BORDER: v = BORDER_RST;
			ADDR_BG0:    v = BG0_RST;
			default:     v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/core/raster_timing_irq_controller.sv =====
// Top level of the raster timing and interrupt controller with stream ports.
`timescale 1ns / 1ps

// Takes one item per clock (tick, register read or register write) and returns one result
// per item. An accepted item sits in an input register; once the output register is free or
// being emptied, the counters and register file update in a single pass and the result lands
// in the output register. The input register takes a new item in the same cycle that the
// item it holds moves on, which sustains one item per clock; when the downstream side stalls
// with both registers full, the input stalls until the result leaves. The register file read
// is done at acceptance from a 64-entry memory with forwarding from the item ahead. No
// clearing pass is needed after reset; the block accepts items from the first cycle.
module raster_timing_irq_controller #(
	parameter int CYCLES_PER_LINE = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // reg_address[5:0], write_data[13:6], zero[15:14]
	input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// read_data[7:0], irq_out[8], bus_avail_low[9], bad_line[10], line_now[19:11],
	// cycle_now[25:20], fetch_row[30:26], fetch_address[44:31], zero[47:45]
	output logic [47:0] m_axis_tdata,
	output logic        m_axis_tuser,  // fetch_valid
	output logic        m_axis_tlast   // frame_end
);

	logic        valid_s1, advance, accept, out_valid_q;
	logic [1:0]  kind_s1;
	logic [5:0]  addr_s1;
	logic [7:0]  data_s1;

	rtic_pkg::ctl_t ctl;
	rtic_pkg::tim_t tim;
	logic [7:0]     rd;
	logic           irq;

	logic [7:0]  rd_q;
	logic        irq_q, ba_q, bad_q, fend_q, fv_q;
	logic [8:0]  line_q;
	logic [5:0]  cycle_q;
	logic [4:0]  row_q;
	logic [13:0] faddr_q;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= s_axis_tuser;
			addr_s1 <= s_axis_tdata[5:0];
			data_s1 <= s_axis_tdata[13:6];
		end
	end

	rtic_timing #(
		.CYCLES_PER_LINE(CYCLES_PER_LINE)
	) u_timing (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (advance && (kind_s1 == rtic_pkg::REQ_TICK)),
		.ctl    (ctl),
		.tim    (tim)
	);

	rtic_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_addr   (s_axis_tdata[5:0]),
		.advance   (advance),
		.kind_s1   (kind_s1),
		.addr_s1   (addr_s1),
		.data_s1   (data_s1),
		.tim       (tim),
		.ctl       (ctl),
		.read_data (rd),
		.irq       (irq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rd_q    <= rd;
			irq_q   <= irq;
			ba_q    <= tim.ba_next;
			bad_q   <= tim.bad_next;
			line_q  <= tim.line_next;
			cycle_q <= tim.cycle_next;
			fend_q  <= tim.frame_end;
			fv_q    <= tim.fetch_valid;
			row_q   <= tim.fetch_row;
			faddr_q <= tim.fetch_addr;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'd0, faddr_q, row_q, cycle_q, line_q, bad_q, ba_q, irq_q, rd_q};
	assign m_axis_tuser  = fv_q;
	assign m_axis_tlast  = fend_q;

	a_ba_needs_bad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ba_q |-> bad_q)
		else $error("bus held on a line that is not a bad line");

	a_fetch_needs_bad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && fv_q |-> bad_q)
		else $error("row fetch requested without a bad line");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && fend_q |-> (line_q == 9'd0) && (cycle_q == 6'd1))
		else $error("frame end without counters at line zero, cycle one");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("stalled item dropped from the input register");

endmodule

// ===== rtl/core/rtic_timing.sv =====
// Cycle and line counters, bad-line latch, bus-available and row fetch request.
`timescale 1ns / 1ps

module rtic_timing #(
	parameter int CYCLES_PER_LINE = 63
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tick,
	input  rtic_pkg::ctl_t   ctl,
	output rtic_pkg::tim_t   tim
);

	localparam int CW = $clog2(CYCLES_PER_LINE + 1);

	logic [CW-1:0] cycle_q, cycle_d;
	logic [8:0]    line_q, line_d;
	logic          bad_q, bad_d;
	logic          ba_q, ba_d;
	logic          in_disp, cond, wrap, frame, fetch;
	logic [8:0]    disp_off;
	logic [4:0]    row;
	logic [10:0]   row_off;
	logic [13:0]   faddr;

	always_comb begin
		in_disp  = (line_q >= rtic_pkg::DISP_FIRST) && (line_q <= rtic_pkg::DISP_LAST);
		cond     = in_disp && ctl.den && (line_q[2:0] == ctl.ysc);
		bad_d    = bad_q;
		if (cycle_q == CW'(rtic_pkg::BAD_LINE_CYCLE)) begin
			bad_d = cond;
		end
		ba_d     = bad_d && (cycle_q >= CW'(rtic_pkg::BAD_LINE_CYCLE))
			&& (cycle_q <= CW'(rtic_pkg::BA_LAST_CYCLE));
		disp_off = line_q - rtic_pkg::DISP_FIRST;
		row      = disp_off[7:3];
		fetch    = (cycle_q == CW'(rtic_pkg::FETCH_CYCLE)) && in_disp && bad_d
			&& (row < 5'(rtic_pkg::TEXT_ROWS));
		row_off  = 11'(row) * 11'(rtic_pkg::TEXT_COLS);
		faddr    = {ctl.matrix_base, 10'd0} + {3'd0, row_off};
		wrap     = (cycle_q == CW'(CYCLES_PER_LINE));
		frame    = wrap && (line_q == rtic_pkg::LINE_LAST);
		cycle_d  = wrap ? CW'(1) : cycle_q + CW'(1);
		if (!wrap) begin
			line_d = line_q;
		end else if (frame) begin
			line_d = '0;
		end else begin
			line_d = line_q + 9'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_q <= CW'(1);
			line_q  <= '0;
			bad_q   <= 1'b0;
			ba_q    <= 1'b0;
		end else if (tick) begin
			cycle_q <= cycle_d;
			line_q  <= line_d;
			bad_q   <= bad_d;
			ba_q    <= ba_d;
		end
	end

	always_comb begin
		tim.line        = line_q;
		tim.cyc_one     = (cycle_q == CW'(1));
		tim.line_next   = tick ? line_d : line_q;
		tim.wrap        = tick && wrap;
		tim.cycle_next  = tick ? cycle_d[5:0] : cycle_q[5:0];
		tim.bad_next    = tick ? bad_d : bad_q;
		tim.ba_next     = tick ? ba_d : ba_q;
		tim.frame_end   = tick && frame;
		tim.fetch_valid = tick && fetch;
		tim.fetch_row   = (tick && fetch) ? row : '0;
		tim.fetch_addr  = (tick && fetch) ? faddr : '0;
	end

endmodule

// ===== rtl/core/rtic_regs.sv =====
// Register file, raster compare and interrupt mask and acknowledge logic.
`timescale 1ns / 1ps

module rtic_regs (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [5:0]      in_addr,
	input  logic            advance,
	input  logic [1:0]      kind_s1,
	input  logic [5:0]      addr_s1,
	input  logic [7:0]      data_s1,
	input  rtic_pkg::tim_t  tim,
	output rtic_pkg::ctl_t  ctl,
	output logic [7:0]      read_data,
	output logic            irq
);

	logic [7:0]  mem [64];
	logic [63:0] vld_q;
	logic [7:0]  rd_mem_s1, byp_data_s1;
	logic        rd_vld_s1, byp_s1;

	logic [7:0] cr1_q, cr1_d, memptr_q, memptr_d, irr_q, irr_d, imr_q, imr_d;
	logic [7:0] mm_q, mm_d, md_q, md_d, rd, mem_word, irr_clr;
	logic [8:0] cmp_q, cmp_d;
	logic       pend_q, pend_d, gen_we;

	assign gen_we = advance && (kind_s1 == rtic_pkg::REQ_WRITE)
		&& (addr_s1 != rtic_pkg::ADDR_CR1) && (addr_s1 != rtic_pkg::ADDR_RASTER)
		&& (addr_s1 != rtic_pkg::ADDR_IRR) && (addr_s1 != rtic_pkg::ADDR_IMR);

	always_ff @(posedge clk) begin
		if (gen_we) begin
			mem[addr_s1] <= data_s1;
		end
		if (accept) begin
			rd_mem_s1   <= mem[in_addr];
			byp_data_s1 <= data_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
			byp_s1    <= 1'b0;
		end else begin
			if (gen_we) begin
				vld_q[addr_s1] <= 1'b1;
			end
			if (accept) begin
				rd_vld_s1 <= vld_q[in_addr];
				byp_s1    <= gen_we && (addr_s1 == in_addr);
			end
		end
	end

	assign mem_word = byp_s1 ? byp_data_s1
		: (rd_vld_s1 ? rd_mem_s1 : rtic_pkg::reg_reset_val(addr_s1));

	always_comb begin
		cr1_d    = cr1_q;
		memptr_d = memptr_q;
		irr_d    = irr_q;
		imr_d    = imr_q;
		mm_d     = mm_q;
		md_d     = md_q;
		cmp_d    = cmp_q;
		pend_d   = pend_q;
		rd       = 8'h00;
		irr_clr  = irr_q & ~(data_s1 & rtic_pkg::IRQ_SRC_MASK);
		case (kind_s1)
			rtic_pkg::REQ_TICK: begin
				if (tim.cyc_one && (tim.line == cmp_q)) begin
					irr_d = irr_q | rtic_pkg::IRQ_RASTER;
					if (imr_q[0]) begin
						irr_d  = irr_q | rtic_pkg::IRQ_RASTER | rtic_pkg::IRQ_ANY;
						pend_d = 1'b1;
					end
				end
				if (tim.wrap) begin
					cr1_d = {tim.line_next[8], cr1_q[6:0]};
				end
			end
			rtic_pkg::REQ_READ: begin
				case (addr_s1)
					rtic_pkg::ADDR_CR1:    rd = {tim.line[8], cr1_q[6:0]};
					rtic_pkg::ADDR_RASTER: rd = tim.line[7:0];
					rtic_pkg::ADDR_IRR:    rd = irr_q | rtic_pkg::IRR_FORCED;
					rtic_pkg::ADDR_IMR:    rd = imr_q | rtic_pkg::IMR_FORCED;
					rtic_pkg::ADDR_MEMPTR: rd = memptr_q;
					rtic_pkg::ADDR_MM: begin
						rd   = mm_q;
						mm_d = 8'h00;
					end
					rtic_pkg::ADDR_MD: begin
						rd   = md_q;
						md_d = 8'h00;
					end
					default: rd = (addr_s1 < rtic_pkg::ADDR_UNUSED) ? mem_word
						: rtic_pkg::OPEN_BUS;
				endcase
			end
			rtic_pkg::REQ_WRITE: begin
				case (addr_s1)
					rtic_pkg::ADDR_CR1: begin
						cr1_d    = data_s1;
						cmp_d[8] = data_s1[7];
					end
					rtic_pkg::ADDR_RASTER: cmp_d[7:0] = data_s1;
					rtic_pkg::ADDR_IRR: begin
						if ((irr_clr & imr_q & rtic_pkg::IRQ_SRC_MASK) == 8'h00) begin
							irr_d  = irr_clr & ~rtic_pkg::IRQ_ANY;
							pend_d = 1'b0;
						end else begin
							irr_d = irr_clr;
						end
					end
					rtic_pkg::ADDR_IMR:    imr_d = data_s1 & rtic_pkg::IRQ_SRC_MASK;
					rtic_pkg::ADDR_MEMPTR: memptr_d = data_s1;
					rtic_pkg::ADDR_MM:     mm_d = data_s1;
					rtic_pkg::ADDR_MD:     md_d = data_s1;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr1_q    <= rtic_pkg::CR1_RST;
			memptr_q <= rtic_pkg::MEMPTR_RST;
			irr_q    <= 8'h00;
			imr_q    <= 8'h00;
			mm_q     <= 8'h00;
			md_q     <= 8'h00;
			cmp_q    <= '0;
			pend_q   <= 1'b0;
		end else if (advance) begin
			cr1_q    <= cr1_d;
			memptr_q <= memptr_d;
			irr_q    <= irr_d;
			imr_q    <= imr_d;
			mm_q     <= mm_d;
			md_q     <= md_d;
			cmp_q    <= cmp_d;
			pend_q   <= pend_d;
		end
	end

	assign ctl.den         = cr1_q[4];
	assign ctl.ysc         = cr1_q[2:0];
	assign ctl.matrix_base = memptr_q[7:4];
	assign read_data       = rd;
	assign irq             = pend_d;

endmodule
